@@ design/mpqs_pkg.sv @@
// ----------------------------------------------------------------------------
// mpqs_pkg: shared types and constants for the min priority queue
// Item layouts of both channels, status codes and the per-cell control.
// ----------------------------------------------------------------------------
package mpqs_pkg;

    localparam int unsigned CAPACITY_DEFAULT      = 16;
    localparam int unsigned PRIORITY_BITS_DEFAULT = 8;
    localparam int unsigned REQ_PRIORITY_W        = 8;
    localparam int unsigned PAYLOAD_W             = 32;

    typedef enum logic
    {
        MODE_INSERT = 1'b0,
        MODE_REMOVE = 1'b1
    } mode_t;

    typedef enum logic [1:0]
    {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_REMOVED  = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef struct packed
    {
        mode_t                        mode;
        logic [REQ_PRIORITY_W-1:0]    priority_req;
        logic signed [PAYLOAD_W-1:0]  payload;
    } req_item_t;

    typedef struct packed
    {
        status_t                      status;
        logic [REQ_PRIORITY_W-1:0]    out_priority;
        logic signed [PAYLOAD_W-1:0]  out_payload;
    } rsp_item_t;

    // Broadcast to every cell of the chain for one accepted item.
    typedef struct packed
    {
        logic push;
        logic pop;
    } cell_op_t;

endpackage

@@ design/mpqs_cell.sv @@
// ----------------------------------------------------------------------------
// mpqs_cell: one slot of the sorted shift-register queue
// Holds one entry; on a push it keeps, takes the new entry or takes its left
// neighbor's entry, and on a pop it takes its right neighbor's entry.
// ----------------------------------------------------------------------------
module mpqs_cell #(
    parameter int unsigned PRI_W = mpqs_pkg::PRIORITY_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  mpqs_pkg::cell_op_t                    op,
    input  logic [PRI_W-1:0]                      new_priority,
    input  logic signed [mpqs_pkg::PAYLOAD_W-1:0] new_payload,
    input  logic                                  occupied,
    input  logic                                  left_ge,
    input  logic [PRI_W-1:0]                      left_priority,
    input  logic signed [mpqs_pkg::PAYLOAD_W-1:0] left_payload,
    input  logic [PRI_W-1:0]                      right_priority,
    input  logic signed [mpqs_pkg::PAYLOAD_W-1:0] right_payload,
    output logic                                  ge,
    output logic [PRI_W-1:0]                      cell_priority,
    output logic signed [mpqs_pkg::PAYLOAD_W-1:0] cell_payload
);

    logic [PRI_W-1:0]                      priority_reg;
    logic [PRI_W-1:0]                      priority_next;
    logic signed [mpqs_pkg::PAYLOAD_W-1:0] payload_reg;
    logic signed [mpqs_pkg::PAYLOAD_W-1:0] payload_next;

    // A new entry goes ahead of every stored entry of equal priority, since
    // the most recent of equals must leave first.
    assign ge = !occupied || (priority_reg >= new_priority);

    always_comb
    begin
        priority_next = priority_reg;
        payload_next  = payload_reg;
        if (op.pop)
        begin
            priority_next = right_priority;
            payload_next  = right_payload;
        end
        else if (op.push && ge)
        begin
            if (left_ge)
            begin
                priority_next = left_priority;
                payload_next  = left_payload;
            end
            else
            begin
                priority_next = new_priority;
                payload_next  = new_payload;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        priority_reg <= priority_next;
        payload_reg  <= payload_next;
    end

    assign cell_priority = priority_reg;
    assign cell_payload  = payload_reg;

endmodule

@@ design/min_priority_queue_scan.sv @@
// ----------------------------------------------------------------------------
// min_priority_queue_scan: fixed-capacity min priority queue
// Each request item inserts a (priority, payload) entry or removes the entry
// with the smallest priority; among equal priorities the latest one leaves.
//
// Channels: req_valid/req_stall/req carry request items, rsp_valid/rsp_stall/
// rsp carry one response item for every request item. An item moves at a
// rising edge with valid high and stall low.
// The entries sit in a chain of cells kept sorted by priority, and by age
// within equal priorities, so the head cell always holds the next entry to
// leave. An insert shifts the tail of the chain right by one cell, a remove
// shifts the whole chain left by one cell.
// The response is registered and valid in the cycle after its request is accepted.
// Throughput: one item per cycle unless a response waits under rsp_stall;
// the per-cell priority compare and head-cell read set it, not the capacity.
// A response that waits under rsp_stall stays in the output register; the
// next request is then held off through req_stall until it is taken.
// Reset empties the queue and drops any waiting response; stored entries
// need no clearing since only cells below the fill count are ever read.
// ----------------------------------------------------------------------------
module min_priority_queue_scan #(
    parameter int unsigned CAPACITY      = mpqs_pkg::CAPACITY_DEFAULT,
    parameter int unsigned PRIORITY_BITS = mpqs_pkg::PRIORITY_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  mpqs_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output mpqs_pkg::rsp_item_t rsp
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned REQ_W = mpqs_pkg::REQ_PRIORITY_W;

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      rsp_valid_reg;
    logic                      rsp_valid_next;
    mpqs_pkg::rsp_item_t       rsp_reg;
    mpqs_pkg::rsp_item_t       rsp_next;

    logic                      accept;
    logic                      full;
    logic                      empty;
    mpqs_pkg::cell_op_t        op;
    logic [PRIORITY_BITS-1:0]  new_priority;
    logic [REQ_W-1:0]          head_priority;

    logic [CAPACITY-1:0]                             occupied;
    logic [CAPACITY-1:0]                             ge;
    logic [PRIORITY_BITS-1:0]                        cell_priority [CAPACITY];
    logic signed [mpqs_pkg::PAYLOAD_W-1:0]           cell_payload  [CAPACITY];

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);

    assign op.push = accept && (req.mode == mpqs_pkg::MODE_INSERT) && !full;
    assign op.pop  = accept && (req.mode == mpqs_pkg::MODE_REMOVE) && !empty;

    // Fit the request priority to the stored width and the head priority
    // back to the response width, bit by bit.
    for (genvar b = 0; b < PRIORITY_BITS; b++)
    begin : g_new_pri
        if (b < REQ_W)
        begin : g_bit
            assign new_priority[b] = req.priority_req[b];
        end
        else
        begin : g_zero
            assign new_priority[b] = 1'b0;
        end
    end

    for (genvar b = 0; b < REQ_W; b++)
    begin : g_head_pri
        if (b < PRIORITY_BITS)
        begin : g_bit
            assign head_priority[b] = cell_priority[0][b];
        end
        else
        begin : g_zero
            assign head_priority[b] = 1'b0;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                                  left_ge;
        logic [PRIORITY_BITS-1:0]              left_priority;
        logic signed [mpqs_pkg::PAYLOAD_W-1:0] left_payload;
        logic [PRIORITY_BITS-1:0]              right_priority;
        logic signed [mpqs_pkg::PAYLOAD_W-1:0] right_payload;

        assign occupied[i] = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_head
            assign left_ge       = 1'b0;
            assign left_priority = cell_priority[i];
            assign left_payload  = cell_payload[i];
        end
        else
        begin : g_body
            assign left_ge       = ge[i-1];
            assign left_priority = cell_priority[i-1];
            assign left_payload  = cell_payload[i-1];
        end

        // The tail cell has no right neighbor; after a pop it lies beyond
        // the fill count, so what it keeps does not matter.
        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_priority = cell_priority[i];
            assign right_payload  = cell_payload[i];
        end
        else
        begin : g_inner
            assign right_priority = cell_priority[i+1];
            assign right_payload  = cell_payload[i+1];
        end

        mpqs_cell #(
            .PRI_W (PRIORITY_BITS)
        ) u_cell (
            .clk            (clk),
            .op             (op),
            .new_priority   (new_priority),
            .new_payload    (req.payload),
            .occupied       (occupied[i]),
            .left_ge        (left_ge),
            .left_priority  (left_priority),
            .left_payload   (left_payload),
            .right_priority (right_priority),
            .right_payload  (right_payload),
            .ge             (ge[i]),
            .cell_priority  (cell_priority[i]),
            .cell_payload   (cell_payload[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (op.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (op.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (accept)
        begin
            rsp_valid_next        = 1'b1;
            rsp_next.out_priority = '0;
            rsp_next.out_payload  = '0;
            if (req.mode == mpqs_pkg::MODE_INSERT)
            begin
                rsp_next.status = full ? mpqs_pkg::ST_FULL : mpqs_pkg::ST_INSERTED;
            end
            else if (empty)
            begin
                rsp_next.status = mpqs_pkg::ST_EMPTY;
            end
            else
            begin
                rsp_next.status       = mpqs_pkg::ST_REMOVED;
                rsp_next.out_priority = head_priority;
                rsp_next.out_payload  = cell_payload[0];
            end
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
    else $error("fill count beyond capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.mode == mpqs_pkg::MODE_REMOVE && empty)
        |=> (rsp_valid && rsp.status == mpqs_pkg::ST_EMPTY && $stable(count_reg)))
    else $error("remove from empty queue not reported as empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        op.push |=> (count_reg == $past(count_reg) + CNT_W'(1)))
    else $error("insert did not grow the fill count");

    assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
    else $error("fill count changed without an accepted item");

endmodule

@@ bench/tb_min_priority_queue_scan.sv @@
// ----------------------------------------------------------------------------
// tb_min_priority_queue_scan: self-checking bench for the min priority queue
// A directed table covers the empty, full, tie and extreme cases. Phases of
// random inserts and removes follow, with varied insert bias and priority
// spread. Each response is compared field by field with a local queue model.
// ----------------------------------------------------------------------------
module tb_min_priority_queue_scan;

    localparam int unsigned DEPTH        = mpqs_pkg::CAPACITY_DEFAULT;
    localparam int unsigned PRI_BITS     = mpqs_pkg::PRIORITY_BITS_DEFAULT;
    localparam int unsigned REQ_PRI_W    = mpqs_pkg::REQ_PRIORITY_W;
    localparam int unsigned DATA_W       = mpqs_pkg::PAYLOAD_W;
    localparam int unsigned RANDOM_ITEMS = 1825;
    localparam int unsigned LONG_HOLD_AT = 300;
    localparam int unsigned LONG_HOLD    = 150;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    localparam logic [REQ_PRI_W-1:0] PRI_MASK = REQ_PRI_W'((1 << PRI_BITS) - 1);

    typedef struct {
        mpqs_pkg::req_item_t item;
        bit                  typed_exp;
        mpqs_pkg::rsp_item_t rsp;
    } plan_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    mpqs_pkg::req_item_t req;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    mpqs_pkg::rsp_item_t rsp;

    // Local copy of the queue contents, in arrival order.
    logic [REQ_PRI_W-1:0]     q_pri [DEPTH];
    logic signed [DATA_W-1:0] q_dat [DEPTH];
    int unsigned              q_fill = 0;

    mpqs_pkg::rsp_item_t pending_rsp [$];
    plan_row_t           plan [$];
    int unsigned         fail_count  = 0;
    int unsigned         cycle_count = 0;

    int unsigned rsp_hold    = 0;
    int unsigned rsp_stretch = 0;
    int unsigned rsp_taken   = 0;
    bit          rsp_calm    = 1'b0;

    min_priority_queue_scan u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #1 clk = ~clk;

    // Applies one request to the local queue and returns its response.
    function automatic mpqs_pkg::rsp_item_t serve_request(input mpqs_pkg::req_item_t r);
        mpqs_pkg::rsp_item_t res;
        int unsigned         sel;
        res = '0;
        res.status = mpqs_pkg::ST_INSERTED;
        if (r.mode == mpqs_pkg::MODE_INSERT)
        begin
            if (q_fill >= DEPTH)
                res.status = mpqs_pkg::ST_FULL;
            else
            begin
                q_pri[q_fill] = r.priority_req & PRI_MASK;
                q_dat[q_fill] = r.payload;
                q_fill++;
            end
        end
        else if (q_fill == 0)
            res.status = mpqs_pkg::ST_EMPTY;
        else
        begin
            // The less-or-equal compare lets the latest of equal minimums win.
            sel = 0;
            for (int unsigned i = 1; i < q_fill; i++)
                if (q_pri[i] <= q_pri[sel])
                    sel = i;
            res.status       = mpqs_pkg::ST_REMOVED;
            res.out_priority = q_pri[sel];
            res.out_payload  = q_dat[sel];
            for (int unsigned i = sel; i + 1 < q_fill; i++)
            begin
                q_pri[i] = q_pri[i + 1];
                q_dat[i] = q_dat[i + 1];
            end
            q_fill--;
        end
        return res;
    endfunction

    task automatic plan_step(input mpqs_pkg::mode_t m, input logic [REQ_PRI_W-1:0] p,
                             input logic signed [DATA_W-1:0] d, input bit typed_exp,
                             input mpqs_pkg::status_t s, input logic [REQ_PRI_W-1:0] op,
                             input logic signed [DATA_W-1:0] od);
        plan_row_t row;
        row.item.mode         = m;
        row.item.priority_req = p;
        row.item.payload      = d;
        row.typed_exp         = typed_exp;
        row.rsp.status        = s;
        row.rsp.out_priority  = op;
        row.rsp.out_payload   = od;
        plan.push_back(row);
    endtask

    // Offers one item, waits for it to be taken, then idles for the given gap.
    task automatic offer_request(input mpqs_pkg::req_item_t item, input bit typed_exp,
                                 input mpqs_pkg::rsp_item_t typed_rsp,
                                 input int unsigned gap);
        mpqs_pkg::rsp_item_t predicted;
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted = serve_request(item);
        pending_rsp.push_back(typed_exp ? typed_rsp : predicted);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Response side: checks each item and draws the stall before the next one.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: response with nothing expected: status %0d prio %02h data %0d",
                         $time, rsp.status, rsp.out_priority, rsp.out_payload);
                fail_count++;
            end
            else
            begin
                if (rsp.status !== pending_rsp[0].status)
                begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, pending_rsp[0].status, rsp.status);
                    fail_count++;
                end
                if (rsp.out_priority !== pending_rsp[0].out_priority)
                begin
                    $display("%0t: out_priority mismatch: expected %02h, actual %02h",
                             $time, pending_rsp[0].out_priority, rsp.out_priority);
                    fail_count++;
                end
                if (rsp.out_payload !== pending_rsp[0].out_payload)
                begin
                    $display("%0t: out_payload mismatch: expected %0d, actual %0d",
                             $time, pending_rsp[0].out_payload, rsp.out_payload);
                    fail_count++;
                end
                void'(pending_rsp.pop_front());
            end
            rsp_taken++;
            if (rsp_taken == LONG_HOLD_AT)
                rsp_hold = LONG_HOLD;
            else
            begin
                if (rsp_stretch == 0)
                begin
                    rsp_stretch = $urandom_range(20, 80);
                    rsp_calm    = ($urandom_range(0, 2) == 0);
                end
                rsp_stretch--;
                rsp_hold = rsp_calm ? 0 : $urandom_range(0, 5);
            end
        end
        else if (rsp_hold != 0)
            rsp_hold--;
        rsp_stall <= (rsp_hold != 0);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("min_priority_queue_scan test failed");
            $finish;
        end
    end

    initial
    begin
        mpqs_pkg::req_item_t item;
        mpqs_pkg::rsp_item_t none;
        int unsigned         sent;
        int unsigned         phase_len;
        int unsigned         ins_pct;
        int unsigned         spread;
        int unsigned         phase_idx;
        bit                  busy;

        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        none      = '0;

        plan_step(mpqs_pkg::MODE_REMOVE, 8'h00, 32'sd0, 1'b1,
                  mpqs_pkg::ST_EMPTY, 8'h00, 32'sd0);
        plan_step(mpqs_pkg::MODE_INSERT, 8'hFF, 32'sh7FFFFFFF, 1'b1,
                  mpqs_pkg::ST_INSERTED, 8'h00, 32'sd0);
        plan_step(mpqs_pkg::MODE_INSERT, 8'h00, 32'sh80000000, 1'b1,
                  mpqs_pkg::ST_INSERTED, 8'h00, 32'sd0);
        plan_step(mpqs_pkg::MODE_INSERT, 8'h00, -32'sd1, 1'b1,
                  mpqs_pkg::ST_INSERTED, 8'h00, 32'sd0);
        // Two entries share the minimum: the later one leaves first. The
        // request fields of a remove carry noise that must be ignored.
        plan_step(mpqs_pkg::MODE_REMOVE, 8'hAA, 32'sh55555555, 1'b1,
                  mpqs_pkg::ST_REMOVED, 8'h00, -32'sd1);
        plan_step(mpqs_pkg::MODE_REMOVE, 8'h00, 32'sd0, 1'b1,
                  mpqs_pkg::ST_REMOVED, 8'h00, 32'sh80000000);
        plan_step(mpqs_pkg::MODE_REMOVE, 8'hFF, -32'sd1, 1'b1,
                  mpqs_pkg::ST_REMOVED, 8'hFF, 32'sh7FFFFFFF);
        plan_step(mpqs_pkg::MODE_REMOVE, 8'h00, 32'sd0, 1'b1,
                  mpqs_pkg::ST_EMPTY, 8'h00, 32'sd0);
        for (int unsigned i = 0; i < DEPTH; i++)
            plan_step(mpqs_pkg::MODE_INSERT, 8'((i % 5) * 60), $urandom, 1'b0,
                      mpqs_pkg::ST_INSERTED, 8'h00, 32'sd0);
        plan_step(mpqs_pkg::MODE_INSERT, 8'h12, 32'sh12345678, 1'b1,
                  mpqs_pkg::ST_FULL, 8'h00, 32'sd0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            offer_request(plan[i].item, plan[i].typed_exp, plan[i].rsp, $urandom_range(0, 5));

        sent      = 0;
        phase_idx = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (phase_idx == 4 || $urandom_range(0, 6) == 0)
            begin
                req_valid <= 1'b0;
                while (pending_rsp.size() != 0)
                    @(posedge clk);
                @(posedge clk);
            end
            phase_len = $urandom_range(30, 90);
            case ($urandom_range(0, 2))
                0:       ins_pct = 90;
                1:       ins_pct = 50;
                default: ins_pct = 15;
            endcase
            spread = $urandom_range(0, 2);
            busy   = ($urandom_range(0, 2) != 0);
            for (int unsigned k = 0; k < phase_len && sent < RANDOM_ITEMS; k++)
            begin
                item.mode = ($urandom_range(0, 99) < ins_pct) ? mpqs_pkg::MODE_INSERT
                                                              : mpqs_pkg::MODE_REMOVE;
                case (spread)
                    0:       item.priority_req = REQ_PRI_W'($urandom_range(0, 3));
                    1:       item.priority_req = REQ_PRI_W'($urandom_range(0, 15));
                    default: item.priority_req = REQ_PRI_W'($urandom_range(0, 255));
                endcase
                if ($urandom_range(0, 15) == 0)
                    item.priority_req = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                item.payload = $urandom;
                offer_request(item, 1'b0, none, busy ? $urandom_range(0, 5) : 0);
                sent++;
            end
            phase_idx++;
        end

        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("min_priority_queue_scan test passed");
        else
            $display("min_priority_queue_scan test failed");
        $finish;
    end

endmodule
